FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types of the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // classification done at the front
  typedef struct packed {
    logic trivial;  // answer known without trial division
    logic flag;     // answer when trivial
  } tdpt_class_t;

endpackage

FILE: rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division, one result beat per candidate beat.
// ----------------------------------------------------------------------------
// A candidate n is tested against divisors d = 2, 3, ... while d*d <= n; each
// divisor costs one bound check plus a pass of the bit-serial remainder unit
// over all VALUE_WIDTH bits of n. A composite stops at its smallest factor,
// and a prime runs through every divisor up to floor(sqrt(n)). Candidates
// below four skip the divisor loop. At the default width the worst case (a
// prime near 2^31) is 46339 divisors. Candidates are taken into a two-entry
// queue while the engine works, and results wait in an output register;
// while that register is held the engine waits with its result, and the
// input stalls once two more candidates are queued. Results come out in
// order.
module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] candidate_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] tested_value_o,
  output logic                   prime_flag_o
);

  logic                    q_full, q_push, q_valid, q_pop;
  logic [VALUE_WIDTH-1:0]  push_value, pop_value;
  tdpt_pkg::tdpt_class_t   push_class, pop_class;

  tdpt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .candidate_i (candidate_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_value_o   (push_value),
    .q_class_o   (push_class)
  );

  tdpt_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_value_i (push_value),
    .push_class_i (push_class),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_value_o  (pop_value),
    .pop_class_o  (pop_class)
  );

  tdpt_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_value_i      (pop_value),
    .q_class_i      (pop_class),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tested_value_o (tested_value_o),
    .prime_flag_o   (prime_flag_o)
  );

endmodule

FILE: rtl/tdpt_front.sv
// ----------------------------------------------------------------------------
// tdpt_front
// Input side: takes candidate beats and sorts out values below four.
// ----------------------------------------------------------------------------
module tdpt_front #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [VALUE_WIDTH-1:0]   candidate_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output logic [VALUE_WIDTH-1:0]   q_value_o,
  output tdpt_pkg::tdpt_class_t    q_class_o
);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_value_o  = candidate_i;

  // below four the divisor loop never runs: prime exactly when above one
  always_comb begin
    q_class_o.trivial = (candidate_i < VALUE_WIDTH'(4));
    q_class_o.flag    = (candidate_i > VALUE_WIDTH'(1));
  end

endmodule

FILE: rtl/tdpt_queue.sv
// ----------------------------------------------------------------------------
// tdpt_queue
// Short queue between front and back, one beat per entry.
// ----------------------------------------------------------------------------
module tdpt_queue #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [VALUE_WIDTH-1:0]   push_value_i,
  input  tdpt_pkg::tdpt_class_t    push_class_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic                     valid_o,
  output logic [VALUE_WIDTH-1:0]   pop_value_o,
  output tdpt_pkg::tdpt_class_t    pop_class_o
);

  localparam int unsigned Depth = tdpt_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);

  logic [VALUE_WIDTH-1:0]  value_q [Depth];
  tdpt_pkg::tdpt_class_t   class_q [Depth];
  logic [PW-1:0]           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    do_push, do_pop;

  assign full_o      = (count_q == CW'(Depth));
  assign valid_o     = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_value_o = value_q[rptr_q];
  assign pop_class_o = class_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      value_q[wptr_q] <= push_value_i;
      class_q[wptr_q] <= push_class_i;
    end
  end

endmodule

FILE: rtl/tdpt_back.sv
// ----------------------------------------------------------------------------
// tdpt_back
// Trial division engine: bit-serial remainder per divisor, running square
// for the bound, result register on the output side.
// ----------------------------------------------------------------------------
module tdpt_back #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  logic [VALUE_WIDTH-1:0]   q_value_i,
  input  tdpt_pkg::tdpt_class_t    q_class_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [VALUE_WIDTH-1:0]   tested_value_o,
  output logic                     prime_flag_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned DW = (W + 1) / 2 + 1;  // divisor, one past sqrt bound
  localparam int unsigned SW = 2 * DW;           // running square of divisor
  localparam int unsigned CW = $clog2(W);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  shift_q, shift_d;
  logic [DW-1:0] div_q, div_d;
  logic [SW-1:0] sq_q, sq_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          flag_q, flag_d;
  logic [W-1:0]  tv_q, tv_d;
  logic          pf_q, pf_d;

  logic [DW:0]   rem_sh;
  logic [DW-1:0] rem_nx;
  logic          emit;

  assign q_pop_o        = (state_q == S_IDLE) && q_valid_i;
  assign emit           = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;
  assign tested_value_o = tv_q;
  assign prime_flag_o   = pf_q;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, shift_q[W-1]};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_nx = DW'(rem_sh - {1'b0, div_q});
    end else begin
      rem_nx = rem_sh[DW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    n_d         = n_q;
    shift_d     = shift_q;
    div_d       = div_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    flag_d      = flag_q;
    tv_d        = tv_q;
    pf_d        = pf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          n_d    = q_value_i;
          flag_d = q_class_i.flag;
          div_d  = DW'(2);
          sq_d   = SW'(4);
          state_d = q_class_i.trivial ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (sq_q > SW'(n_q)) begin
          flag_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          shift_d = n_q;
          rem_d   = '0;
          cnt_d   = CW'(W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d   = rem_nx;
        shift_d = {shift_q[W-2:0], 1'b0};
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (rem_nx == '0) begin
            flag_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_d    = sq_q + SW'({div_q, 1'b1});
            div_d   = div_q + DW'(1);
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (emit) begin
          tv_d        = n_q;
          pf_d        = flag_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    shift_q <= shift_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    flag_q  <= flag_d;
    tv_q    <= tv_d;
    pf_q    <= pf_d;
  end

endmodule

FILE: rtl/tdpt_checker.sv
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks on the candidate and result channels of the prime test.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpt_checker #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [VALUE_WIDTH-1:0] candidate_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [VALUE_WIDTH-1:0] tested_value_o,
  input logic                   prime_flag_o
);

  logic             stalled;
  logic             in_wait;
  logic [VALUE_WIDTH:0] out_beat;
  logic             low_value;
  logic             two_or_three;
  logic             even_above_two;

  assign stalled        = out_valid_o && !out_ready_i;
  assign in_wait        = in_valid_i && !in_ready_o;
  assign out_beat       = {tested_value_o, prime_flag_o};
  assign low_value      = out_valid_o && (tested_value_o < VALUE_WIDTH'(2));
  assign two_or_three   = out_valid_o && ((tested_value_o == VALUE_WIDTH'(2)) ||
                                          (tested_value_o == VALUE_WIDTH'(3)));
  assign even_above_two = out_valid_o && !tested_value_o[0] &&
                          (tested_value_o > VALUE_WIDTH'(2));

  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(candidate_i))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(out_beat))
  `ASSERT_IMPLIES(a_zero_one, clk_i, rst_ni, low_value, !prime_flag_o)
  `ASSERT_IMPLIES(a_two_three, clk_i, rst_ni, two_or_three, prime_flag_o)
  `ASSERT_IMPLIES(a_even, clk_i, rst_ni, even_above_two, !prime_flag_o)

endmodule

bind trial_division_prime_test tdpt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tdpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .candidate_i    (candidate_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .tested_value_o (tested_value_o),
  .prime_flag_o   (prime_flag_o)
);

FILE: dv/trial_division_prime_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// Self-checking bench for the trial division prime test. Candidate beats go
// in through valid/ready, and a scoreboard works out the expected verdict of
// each accepted beat by its own trial division. Every result beat is checked
// in order against the oldest verdict. The run steps through phases in which
// the sender idles, the receiver idles, and neither idles. It also holds off
// the receiver long enough to back the block up.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

  localparam int unsigned W = tdpt_pkg::VALUE_WIDTH_DEF;

  typedef logic [W-1:0] value_t;

  typedef struct {
    value_t value;
    logic   prime;
  } verdict_t;

  class prime_scoreboard;
    verdict_t pending_verdicts[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic is_prime_by_division(value_t n);
      longint unsigned num;
      longint unsigned d;
      num = longint'(n);
      d   = 2;
      while (d <= num / d) begin
        if (num % d == 0) return 1'b0;
        d++;
      end
      return (num > 1) ? 1'b1 : 1'b0;
    endfunction

    function void note_candidate(value_t n);
      verdict_t v;
      v.value = n;
      v.prime = is_prime_by_division(n);
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(value_t tested, logic prime);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result beat: tested_value %0d prime_flag %0d", tested, prime);
        mismatches++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (tested !== v.value) begin
        $error("tested_value: expected %0d, got %0d", v.value, tested);
        mismatches++;
      end
      if (prime !== v.prime) begin
        $error("prime_flag: expected %0d, got %0d (candidate %0d)", v.prime, prime, v.value);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  value_t candidate_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  value_t tested_value_o;
  logic   prime_flag_o;

  int   in_idle_pct   = 0;
  int   out_idle_pct  = 0;
  logic hold_off_req  = 1'b0;

  prime_scoreboard sb = new();

  // extremes, tiny cases, squares of primes, large primes and composites
  value_t directed_vals [23] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 9, 15, 25, 97, 121, 63001, 65535, 65536, 65537,
    1000003, 715827882, 1431655765, 1073741824, 2147483646, 2147483647
  };

  trial_division_prime_test u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .candidate_i   (candidate_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tested_value_o(tested_value_o),
    .prime_flag_o  (prime_flag_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // most candidates are cheap; full-width ones carry a small factor
  function automatic value_t next_random_candidate();
    int          bucket;
    int unsigned factor;
    int unsigned raw;
    bucket = $urandom_range(0, 99);
    if (bucket < 35) begin
      return value_t'($urandom_range(0, 1023));
    end else if (bucket < 65) begin
      factor = $urandom_range(2, 64);
      raw    = $urandom & 32'h7FFF_FFFF;
      return value_t'((raw / factor) * factor);
    end else if (bucket < 90) begin
      return value_t'($urandom_range(0, (1 << 20) - 1));
    end else begin
      return value_t'($urandom_range(0, (1 << 22) - 1));
    end
  endfunction

  task automatic send_candidate(value_t n);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= n;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_candidate(n);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: check each beat, then pick ready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(tested_value_o, prime_flag_o);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rst_ni && ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_idle_pct  = 22;
    out_idle_pct = 68;
    foreach (directed_vals[i]) send_candidate(directed_vals[i]);
    repeat (27) send_candidate(next_random_candidate());

    in_idle_pct  = 68;
    out_idle_pct = 22;
    repeat (27) send_candidate(next_random_candidate());
    wait_drained();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    // receiver stalls while cheap beats keep coming, so the input backs up
    hold_off_req = 1'b1;
    repeat (6) send_candidate(value_t'($urandom_range(0, 63)));
    repeat (17) send_candidate(next_random_candidate());
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("trial_division_prime_test verification clean");
    end else begin
      $display("trial_division_prime_test verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("trial_division_prime_test verification failed");
    $finish;
  end

endmodule
